@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define CFPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define CFPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cfpr_pkg.sv @@
package cfpr_pkg;

    // Default sizes
    localparam int unsigned CFPR_IMAGE_DEPTH = 4096;
    localparam int unsigned CFPR_MAX_ROWS    = 1048576;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_ELEM  = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    // Fixed point widths
    localparam int unsigned SUM_W   = 40;
    localparam int unsigned RATIO_W = 32;
    localparam int unsigned ALU_W   = 42;
    localparam int unsigned RECIP_SHIFT = 24;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DIV_CHK,
        ST_DIV,
        ST_DONE
    } cfpr_state_t;

endpackage

@@ rtl/csr_forward_projection_ratio_top.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+-------------------------------------------------------
// input   | in_valid / in_stall | mode, column, image_value, matrix_value, last_in_row,
//         |                     | measured_count
// output  | out_valid/out_stall | row_index, forward_sum, ratio, saturated
//
// One item is worked on at a time; in_stall stays high until the sequencer is back in idle.
// States: image write INDEX, WRITE; matrix element INDEX, READ, MUL, ACC; unused mode none.
// A row end adds DIV_CHK, then DIV unless the sum is zero or the ratio clips (one quotient
// bit per cycle on the shared add/subtract unit), then DONE plus any output register wait.
// Reset (rst_n, asynchronous) clears the accumulator, the row counter and the clip flag;
// the image store has no reset and must be written before it is read.
// A result waits in the output register under out_stall; the next item is still taken.

`include "assert_macros.svh"

module csr_forward_projection_ratio_top
    import cfpr_pkg::*;
#(
    parameter int unsigned IMAGE_DEPTH = CFPR_IMAGE_DEPTH,
    parameter int unsigned MAX_ROWS    = CFPR_MAX_ROWS
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   mode,
    input  logic [11:0]  column,
    input  logic [31:0]  image_value,
    input  logic [15:0]  matrix_value,
    input  logic         last_in_row,
    input  logic [15:0]  measured_count,

    output logic         out_valid,
    input  logic         out_stall,
    output logic [19:0]  row_index,
    output logic [39:0]  forward_sum,
    output logic [31:0]  ratio,
    output logic         saturated
);

    // Store index width and column reduction constants.
    localparam int unsigned IDX_W  = $clog2(IMAGE_DEPTH);
    localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned ROWX_W = (ROW_W > 20) ? ROW_W : 20;
    localparam logic [23:0] RECIP  = 24'((64'd1 << RECIP_SHIFT) / IMAGE_DEPTH);
    localparam logic [21:0] DEPTH_L   = 22'(IMAGE_DEPTH);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    // Sequencer
    cfpr_state_t state_reg, state_next;

    // Captured item
    logic [1:0]  mode_reg;
    logic [11:0] column_reg;
    logic [31:0] image_reg;
    logic [15:0] matrix_reg;
    logic        last_reg;
    logic [15:0] count_reg;
    logic [11:0] q_reg;

    // Datapath
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [31:0]        rd_reg;
    logic [31:0]        prod_reg;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic               clip_reg, clip_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [RATIO_W-1:0] quo_reg, quo_next;
    logic               rsat_reg, rsat_next;
    logic [4:0]         cnt_reg, cnt_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [19:0]        row_index_reg;
    logic [SUM_W-1:0]   forward_sum_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               saturated_reg;

    // Image store
    logic [31:0] mem [IMAGE_DEPTH];

    // Control
    logic in_take;
    logic load_out;
    logic mem_we;
    logic mem_re;
    logic alu_sub;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic alu_borrow;

    // Column reduction: estimate quotient, then remainder with one correction
    logic [35:0] q_prod;
    logic [33:0] qd_prod;
    logic [21:0] rem_raw, rem_fix;
    logic [47:0] mul_full;
    logic [ROWX_W-1:0] row_ext;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && (state_reg == ST_IDLE);

    assign q_prod  = 36'(column) * 36'(RECIP);
    assign qd_prod = 34'(q_reg) * 34'(IMAGE_DEPTH);
    assign rem_raw = 22'(column_reg) - qd_prod[21:0];
    assign rem_fix = (rem_raw >= DEPTH_L) ? (rem_raw - DEPTH_L) : rem_raw;

    assign mul_full = 48'(matrix_reg) * 48'(rd_reg);

    // Shared add/subtract unit: accumulate, overflow check and divide steps
    assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_borrow = alu_res[ALU_W-1];

    assign row_ext = ROWX_W'(row_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_WRITE: state_next = ST_INDEX;
                        MODE_ELEM:  state_next = ST_INDEX;
                        MODE_EMPTY: state_next = ST_DIV_CHK;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INDEX:   state_next = (mode_reg == MODE_WRITE) ? ST_WRITE : ST_READ;
            ST_WRITE:   state_next = ST_IDLE;
            ST_READ:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_ACC;
            ST_ACC:     state_next = last_reg ? ST_DIV_CHK : ST_IDLE;
            ST_DIV_CHK:
            begin
                if ((acc_reg == '0) || !alu_borrow)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:     state_next = (cnt_reg == 5'd31) ? ST_DONE : ST_DIV;
            ST_DONE:    state_next = load_out ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_out = 1'b0;
        alu_sub  = 1'b0;
        alu_a    = 42'(acc_reg);
        alu_b    = 42'(prod_reg);
        case (state_reg)
            ST_WRITE: mem_we = 1'b1;
            ST_READ:  mem_re = 1'b1;
            ST_DIV_CHK:
            begin
                alu_sub = 1'b1;
                alu_a   = 42'(count_reg);
                alu_b   = 42'(acc_reg);
            end
            ST_DIV:
            begin
                alu_sub = 1'b1;
                alu_a   = 42'({rem_reg, 1'b0});
                alu_b   = 42'(acc_reg);
            end
            ST_DONE:  load_out = !out_valid_reg || !out_stall;
            default:  mem_we = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        row_next       = row_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        rsat_next      = rsat_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_INDEX: idx_next = rem_fix[IDX_W-1:0];
            ST_ACC:
            begin
                // Saturate the row sum
                if (alu_res[ALU_W-1:SUM_W] != '0)
                begin
                    acc_next  = SUM_MAX;
                    clip_next = 1'b1;
                end
                else
                begin
                    acc_next = alu_res[SUM_W-1:0];
                end
            end
            ST_DIV_CHK:
            begin
                rem_next = 40'(count_reg);
                cnt_next = '0;
                if (acc_reg == '0)
                begin
                    quo_next  = '0;
                    rsat_next = 1'b0;
                end
                else if (!alu_borrow)
                begin
                    // count >= sum: quotient does not fit in 32 bits
                    quo_next  = RATIO_MAX;
                    rsat_next = 1'b1;
                end
                else
                begin
                    rsat_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                rem_next = alu_borrow ? {rem_reg[SUM_W-2:0], 1'b0} : alu_res[SUM_W-1:0];
                quo_next = {quo_reg[RATIO_W-2:0], !alu_borrow};
                cnt_next = cnt_reg + 5'd1;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    clip_next      = 1'b0;
                    row_next       = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
                end
            end
            default: idx_next = idx_reg;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            row_reg       <= row_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg   <= mode;
            column_reg <= column;
            image_reg  <= image_value;
            matrix_reg <= matrix_value;
            last_reg   <= last_in_row;
            count_reg  <= measured_count;
            q_reg      <= q_prod[35:RECIP_SHIFT];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_full[47:16];
        end
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rsat_reg <= rsat_next;
        cnt_reg  <= cnt_next;
        if (load_out)
        begin
            row_index_reg   <= row_ext[19:0];
            forward_sum_reg <= acc_reg;
            ratio_reg       <= quo_reg;
            saturated_reg   <= clip_reg || rsat_reg;
        end
    end

    // Image store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= image_reg;
        end
        if (mem_re)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_index_reg;
    assign forward_sum = forward_sum_reg;
    assign ratio       = ratio_reg;
    assign saturated   = saturated_reg;

    // Checks
    `CFPR_ASSERT(a_idx_range, ((state_reg == ST_WRITE) || (state_reg == ST_READ)) |-> (32'(idx_reg) < 32'(IMAGE_DEPTH)), "store index out of range")
    `CFPR_ASSERT(a_rem_below, (state_reg == ST_DIV) |-> (rem_reg < acc_reg), "divide remainder not below divisor")
    `CFPR_ASSERT(a_row_clear, load_out |=> ((acc_reg == '0) && !clip_reg), "row state not cleared after result")
    `CFPR_ASSERT_ALWAYS(a_zero_ratio, out_valid |-> ((forward_sum != '0) || (ratio == '0)), "nonzero ratio on zero sum")

endmodule

@@ tb/sv/csr_forward_projection_ratio_top_test.sv @@
`timescale 1ns / 1ps

module csr_forward_projection_ratio_top_test
    import cfpr_pkg::*;
();

    // Mode 3 has no meaning to the block; it is sent only as noise.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned IMAGE_ENTRIES = 4096;
    localparam int unsigned RANDOM_ITEMS  = 1950;
    // Elements of a row that drives the accumulator into its clip: each full-scale
    // product is just under 2^32, so 257 of them pass 2^40-1.
    localparam int unsigned HEAVY_ROW_LEN = 260;
    // A row end runs the whole divide and then waits on the output register; allow some slack.
    localparam int unsigned DRAIN_CYCLES  = 64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] column;
        logic [31:0] image_value;
        logic [15:0] matrix_value;
        logic        last_in_row;
        logic [15:0] measured_count;
    } item_t;

    typedef struct packed {
        logic [19:0] row_index;
        logic [39:0] forward_sum;
        logic [31:0] ratio;
        logic        saturated;
    } row_result_t;

    typedef struct packed {
        item_t       stim;
        logic        known;
        row_result_t want;
    } directed_row_t;

    localparam row_result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_WRITE;
    logic [11:0] column = '0;
    logic [31:0] image_value = '0;
    logic [15:0] matrix_value = '0;
    logic        last_in_row = 1'b0;
    logic [15:0] measured_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [19:0] row_index;
    logic [39:0] forward_sum;
    logic [31:0] ratio;
    logic        saturated;

    // Predictor state: its own image copy, the running row sum, the row number
    // and the sticky clip seen while summing the current row.
    logic [31:0] image_model [IMAGE_ENTRIES];
    logic [39:0] row_sum = '0;
    logic [19:0] row_number = '0;
    logic        sum_clip_seen = 1'b0;

    // Columns written so far; elements only ever read these, since the store
    // holds garbage until written.
    bit          col_written [IMAGE_ENTRIES];
    int unsigned written_cols [$];

    row_result_t pending_rows [$];
    int unsigned mismatches = 0;
    // Set during stretches where neither side idles.
    bit          no_idle = 1'b0;

    // Directed part: the sums and ratios typed in are the ones that fall out
    // of powers of two; the rest go through the predictor.
    directed_row_t directed_plan [20] = '{
        // Empty row straight out of reset: zero sum, zero ratio, row 0.
        '{'{MODE_EMPTY, 12'd0, 32'h0, 16'h0, 1'b0, 16'd5}, 1'b1,
          '{20'd0, 40'h0, 32'h0, 1'b0}},
        // Fill extremes of the store; unused fields carry junk.
        '{'{MODE_WRITE, 12'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
        '{'{MODE_WRITE, 12'd4095, 32'h0001_0000, 16'h0, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_WRITE, 12'd1, 32'h0, 16'h0, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        // 0.5 * 1.0 = 0.5, and 1 / 0.5 = 2.0.
        '{'{MODE_ELEM, 12'd4095, 32'h1234_5678, 16'h8000, 1'b1, 16'd1}, 1'b1,
          '{20'd1, 40'h8000, 32'h0002_0000, 1'b0}},
        // Two full-scale elements, largest count.
        '{'{MODE_ELEM, 12'd0, 32'h0, 16'hFFFF, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_ELEM, 12'd0, 32'h0, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
        // Zero image entry gives a zero sum: ratio zero, no clip.
        '{'{MODE_ELEM, 12'd1, 32'h0, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b1,
          '{20'd3, 40'h0, 32'h0, 1'b0}},
        // Product truncates to zero.
        '{'{MODE_WRITE, 12'd2, 32'h0000_0001, 16'h0, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_ELEM, 12'd2, 32'h0, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b1,
          '{20'd4, 40'h0, 32'h0, 1'b0}},
        // Smallest nonzero sum against count 2: ratio clips.
        '{'{MODE_WRITE, 12'd2, 32'h0001_0000, 16'h0, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_ELEM, 12'd2, 32'h0, 16'h0001, 1'b1, 16'd2}, 1'b1,
          '{20'd5, 40'h1, 32'hFFFF_FFFF, 1'b1}},
        // Unused mode with every field high: nothing happens.
        '{'{MODE_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
        // Image write in the middle of a row, row closed by an empty-row item.
        '{'{MODE_ELEM, 12'd4095, 32'h0, 16'h8000, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_WRITE, 12'd4095, 32'h0002_0000, 16'h0, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_ELEM, 12'd4095, 32'h0, 16'h8000, 1'b0, 16'h0}, 1'b0, NO_RESULT},
        '{'{MODE_EMPTY, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'd3}, 1'b1,
          '{20'd6, 40'h1_8000, 32'h0002_0000, 1'b0}},
        // Nonzero sum with zero count.
        '{'{MODE_ELEM, 12'd4095, 32'h0, 16'hFFFF, 1'b1, 16'h0}, 1'b0, NO_RESULT},
        // Zero weight on a full-scale entry.
        '{'{MODE_ELEM, 12'd0, 32'h0, 16'h0, 1'b1, 16'hFFFF}, 1'b1,
          '{20'd8, 40'h0, 32'h0, 1'b0}},
        '{'{MODE_EMPTY, 12'd0, 32'h0, 16'h0, 1'b0, 16'hFFFF}, 1'b1,
          '{20'd9, 40'h0, 32'h0, 1'b0}}
    };

    csr_forward_projection_ratio_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .column         (column),
        .image_value    (image_value),
        .matrix_value   (matrix_value),
        .last_in_row    (last_in_row),
        .measured_count (measured_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_index      (row_index),
        .forward_sum    (forward_sum),
        .ratio          (ratio),
        .saturated      (saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Append a row to the list of results still owed by the block.
    function automatic void log_row(input row_result_t r);
        pending_rows.insert(pending_rows.size(), r);
    endfunction

    // Append a column to the list of written columns.
    function automatic void log_column(input logic [11:0] col);
        written_cols.insert(written_cols.size(), 32'(col));
    endfunction

    // Advance the predictor by one item; return 1 when the item closes a row.
    function automatic bit forward_project(input item_t it, output row_result_t res);
        logic [47:0] product;
        logic [40:0] total;
        logic [47:0] quotient;
        bit          closes;
        res = NO_RESULT;
        closes = 1'b0;
        if (it.mode == MODE_WRITE)
        begin
            image_model[it.column] = it.image_value;
        end
        else if (it.mode == MODE_ELEM)
        begin
            // Q0.16 * Q16.16 = Q16.32; drop 16 bits to get Q16.16, summed in Q24.16.
            product = {32'b0, it.matrix_value} * {16'b0, image_model[it.column]};
            total = {1'b0, row_sum} + {9'b0, product[47:16]};
            if (total > {1'b0, SUM_MAX})
            begin
                row_sum = SUM_MAX;
                sum_clip_seen = 1'b1;
            end
            else
            begin
                row_sum = total[39:0];
            end
            closes = it.last_in_row;
        end
        else if (it.mode == MODE_EMPTY)
        begin
            closes = 1'b1;
        end

        if (closes)
        begin
            res.row_index = row_number;
            res.forward_sum = row_sum;
            res.saturated = sum_clip_seen;
            if (row_sum != '0)
            begin
                quotient = {it.measured_count, 32'b0} / {8'b0, row_sum};
                if (quotient > {16'b0, RATIO_MAX})
                begin
                    res.ratio = RATIO_MAX;
                    res.saturated = 1'b1;
                end
                else
                begin
                    res.ratio = quotient[31:0];
                end
            end
            row_sum = '0;
            sum_clip_seen = 1'b0;
            // MAX_ROWS is 2^20, so the 20-bit counter wraps on its own.
            row_number = row_number + 20'd1;
        end
        return closes;
    endfunction

    // Lean on extremes and tiny values so zero sums and ratio clips show up often.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t noise_item(input logic [1:0] item_mode);
        item_t       it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.mode = item_mode;
        return it;
    endfunction

    function automatic item_t write_item(input logic [11:0] col, input logic [31:0] value);
        item_t it;
        it = noise_item(MODE_WRITE);
        it.column = col;
        it.image_value = value;
        return it;
    endfunction

    // Element on a column that already holds a value.
    function automatic item_t element_item(input bit last);
        item_t it;
        it = noise_item(MODE_ELEM);
        it.column = 12'(written_cols[$urandom_range(0, written_cols.size() - 1)]);
        it.matrix_value = pick16();
        it.last_in_row = last;
        it.measured_count = pick16();
        return it;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Hold the item until accepted, then log what it should produce.
    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic issue_item(input item_t it, input bit known, input row_result_t known_res);
        row_result_t res;
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= it.mode;
        column         <= it.column;
        image_value    <= it.image_value;
        matrix_value   <= it.matrix_value;
        last_in_row    <= it.last_in_row;
        measured_count <= it.measured_count;
        do @(posedge clk); while (in_stall);

        if (it.mode == MODE_WRITE && !col_written[it.column])
        begin
            col_written[it.column] = 1'b1;
            log_column(it.column);
        end
        if (forward_project(it, res))
            log_row(known ? known_res : res);
    endtask

    // Result side: draw a stall for every result, then take it and compare
    // it field by field with the oldest pending row.
    initial
    begin
        row_result_t want;
        int unsigned stall_len;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall_len = no_idle ? 0 : $urandom_range(0, 14);
            if (stall_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);

            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row result: expected none, actual row %0d sum %0h",
                         $time, row_index, forward_sum);
                mismatches++;
            end
            else
            begin
                want = pending_rows.pop_front();
                check_field("row_index", 64'(want.row_index), 64'(row_index));
                check_field("forward_sum", 64'(want.forward_sum), 64'(forward_sum));
                check_field("ratio", 64'(want.ratio), 64'(ratio));
                check_field("saturated", 64'(want.saturated), 64'(saturated));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("csr_forward_projection_ratio_top_test: FAIL");
        $finish;
    end

    // Stimulus: reset, directed table, then random row sequences.
    initial
    begin
        item_t       it;
        int unsigned pick;
        int unsigned len;
        int unsigned items_sent;
        int unsigned heavy_rows;
        logic [11:0] heavy_col;
        bit          close_by_empty;

        items_sent = 0;
        heavy_rows = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (directed_plan[k])
            issue_item(directed_plan[k].stim, directed_plan[k].known, directed_plan[k].want);

        while (items_sent < RANDOM_ITEMS)
        begin
            // Flip between idling and back-to-back stretches now and then.
            if ($urandom_range(0, 19) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                issue_item(write_item(12'($urandom), pick32()), 1'b0, NO_RESULT);
                items_sent++;
            end
            else if (pick < 20)
            begin
                // Noise the block must ignore; not counted.
                issue_item(noise_item(MODE_UNUSED), 1'b0, NO_RESULT);
            end
            else if (pick < 26)
            begin
                // Close whatever is open, often a truly empty row.
                it = noise_item(MODE_EMPTY);
                it.measured_count = pick16();
                issue_item(it, 1'b0, NO_RESULT);
                items_sent++;
            end
            else if (pick < 28 && heavy_rows < 2 && items_sent > 300)
            begin
                // Full-scale row long enough to clip the sum.
                heavy_col = 12'($urandom);
                issue_item(write_item(heavy_col, 32'hFFFF_FFFF), 1'b0, NO_RESULT);
                for (int i = 0; i < HEAVY_ROW_LEN; i++)
                begin
                    it = noise_item(MODE_ELEM);
                    it.column = heavy_col;
                    it.matrix_value = 16'hFFFF;
                    it.last_in_row = (i == HEAVY_ROW_LEN - 1);
                    issue_item(it, 1'b0, NO_RESULT);
                end
                items_sent += HEAVY_ROW_LEN + 1;
                heavy_rows++;
            end
            else
            begin
                // Well-formed row, mostly short, sometimes long; drop in a write
                // now and then and close some rows with an empty-row item.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                close_by_empty = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        issue_item(write_item(12'($urandom), pick32()), 1'b0, NO_RESULT);
                        items_sent++;
                    end
                    issue_item(element_item(!close_by_empty && i == len - 1), 1'b0, NO_RESULT);
                    items_sent++;
                end
                if (close_by_empty)
                begin
                    it = noise_item(MODE_EMPTY);
                    it.measured_count = pick16();
                    issue_item(it, 1'b0, NO_RESULT);
                    items_sent++;
                end
            end
        end

        // Drop valid, drain the results, then let the block settle.
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("csr_forward_projection_ratio_top_test: PASS");
        else
            $display("csr_forward_projection_ratio_top_test: FAIL");
        $finish;
    end

endmodule
